### src/resyncing_frame_deframer_assert.svh
// assertion macros shared by the deframer rtl
`ifndef RESYNCING_FRAME_DEFRAMER_ASSERT_SVH
`define RESYNCING_FRAME_DEFRAMER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define RFD_ASSERT_NOW(name, clk, rst_n, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("rfd assertion failed");

// condition holds in the cycle after the trigger
`define RFD_ASSERT_NEXT(name, clk, rst_n, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("rfd assertion failed");

`endif

### src/rfd_pkg.sv
// types and constants of the frame deframer
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 48;
    localparam logic [7:0] START_BYTE = 8'hEF;
    localparam int HEADER_BYTES = 6;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_PAYLOAD  = 3'd1,
        KIND_NO_START = 3'd2,
        KIND_NOISE    = 3'd3,
        KIND_LEN_BAD  = 3'd4,
        KIND_SUM_BAD  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_SUM_RD,
        ST_SUM_ADD,
        ST_HDR_EMIT,
        ST_PAY_RD,
        ST_PAY_EMIT,
        ST_FINISH
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         device_id;
        logic [7:0]         system_id;
        logic [7:0]         message_id;
        logic [7:0]         seq_number;
        logic [5:0]         payload_length;
        logic [7:0]         payload_byte;
        logic [COUNT_W-1:0] dropped_count;
        logic [7:0]         received_sum;
        logic [7:0]         expected_sum;
        logic               last;
        logic [COUNT_W-1:0] buffered_count;
    } result_t;

endpackage

`default_nettype wire

### src/rfd_if.sv
// stream interfaces for received bytes and deframer results
`timescale 1ns / 1ps
`default_nettype none

interface rfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] device_id;
    logic [7:0] system_id;
    logic [7:0] message_id;
    logic [7:0] seq_number;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic [6:0] dropped_count;
    logic [7:0] received_sum;
    logic [7:0] expected_sum;
    logic       last;
    logic [6:0] buffered_count;

    modport source (
        output valid, input ready,
        output kind, output device_id, output system_id, output message_id,
        output seq_number, output payload_length, output payload_byte,
        output dropped_count, output received_sum, output expected_sum,
        output last, output buffered_count
    );
    modport sink (
        input valid, output ready,
        input kind, input device_id, input system_id, input message_id,
        input seq_number, input payload_length, input payload_byte,
        input dropped_count, input received_sum, input expected_sum,
        input last, input buffered_count
    );
endinterface

`default_nettype wire

### src/resyncing_frame_deframer.sv
// top level of the resynchronizing byte-stream frame deframer
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per rx transaction and delivers decoded results on
// res. A frame is start byte 0xEF, device id, system id, message id, sequence,
// payload length, payload and an 8-bit additive checksum of all earlier frame
// bytes. Bytes ahead of a start byte come out as one noise result; a length
// above MAX_PAYLOAD or a bad checksum drops only the start byte and the buffer
// is scanned again. A good frame gives a header result then one result per
// payload byte; the final result caused by a byte carries last, and a byte that
// completes nothing gives no result. A two-entry receive queue feeds a parse
// engine that walks a 64-byte buffer through one registered read port. A byte
// that extends a waiting frame rereads its start and length bytes; the byte
// that completes a frame runs a checksum walk then a payload read-out; noise
// scans visit each byte examined. Results leave through a staging register and
// an output register, so the parser keeps working while a result waits on res;
// it stalls only when both registers are full and res is not ready.
// No clearing pass after reset: buffer entries are only read after written.

module resyncing_frame_deframer #(
    parameter int MAX_PAYLOAD = rfd_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rfd_in_if.sink    rx,
    rfd_out_if.source res
);
    import rfd_pkg::*;

    byte_item_t q_head;
    logic       q_pop;

    // receive queue, decouples the link from the parse engine
    rfd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .pop   (q_pop),
        .head  (q_head)
    );

    // buffer, scan, checksum and result staging
    rfd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .pop   (q_pop),
        .res   (res)
    );

endmodule

`default_nettype wire

### src/rfd_front.sv
// receive side: two-entry byte queue in front of the parser
`timescale 1ns / 1ps
`default_nettype none

module rfd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    rfd_in_if.sink               rx,
    input  wire logic            pop,
    output rfd_pkg::byte_item_t  head
);
    import rfd_pkg::*;

    logic [7:0] data_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       push, do_pop;

    assign rx.ready = (count_reg != 2'd2);
    assign push     = rx.valid && rx.ready;
    assign do_pop   = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.data  = data_reg[rd_ptr_reg];

    always_comb
    begin
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

### src/rfd_back.sv
// parse engine: byte buffer, frame scan, checksum walk and result staging
`timescale 1ns / 1ps
`default_nettype none

module rfd_back #(
    parameter int MAX_PAYLOAD = rfd_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rfd_pkg::byte_item_t head,
    output logic                 pop,
    rfd_out_if.source            res
);
    import rfd_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [7:0]         mem [STORE_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    parse_state_t       state_reg, state_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         hdr_reg [1:4];
    logic [7:0]         hdr_next [1:4];

    result_t            held_reg, out_reg, out_next;
    logic               held_v_reg, out_v_reg;

    logic               emit_req, emit_fire, flush_fire, out_free;
    result_t            emit_res;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] consume;

    assign total    = COUNT_W'(len_reg[5:0]) + COUNT_W'(HEADER_BYTES + 1);
    assign rd_addr  = head_reg + idx_reg[ADDR_W-1:0];
    assign wr_addr  = head_reg + fill_reg[ADDR_W-1:0];
    assign out_free = !out_v_reg || res.ready;
    assign emit_fire = emit_req && (!held_v_reg || out_free);

    // staged result moves to the output register, last only on the flush
    always_comb
    begin
        out_next      = held_reg;
        out_next.last = flush_fire;
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        hdr_next   = hdr_reg;
        pop        = 1'b0;
        emit_req   = 1'b0;
        flush_fire = 1'b0;
        consume    = '0;
        emit_res   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (fill_reg == COUNT_W'(STORE_DEPTH))
                    begin
                        head_next = head_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        fill_next = fill_reg + COUNT_W'(1);
                    end
                    state_next = ST_TOP;
                end
            end
            ST_TOP:
            begin
                idx_next = '0;
                state_next = (fill_reg == '0) ? ST_FINISH : ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (rd_data_reg == START_BYTE)
                begin
                    if (idx_reg == '0)
                    begin
                        if (fill_reg < COUNT_W'(HEADER_BYTES))
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            idx_next   = COUNT_W'(HEADER_BYTES - 1);
                            state_next = ST_LEN_RD;
                        end
                    end
                    else
                    begin
                        // noise ahead of a start byte
                        emit_req = 1'b1;
                        consume  = idx_reg;
                        emit_res.kind = KIND_NOISE;
                        emit_res.dropped_count  = idx_reg;
                        emit_res.buffered_count = fill_reg - idx_reg;
                        if (emit_fire)
                        begin
                            state_next = ST_TOP;
                        end
                    end
                end
                else if (idx_reg + COUNT_W'(1) == fill_reg)
                begin
                    // whole buffer is noise
                    emit_req = 1'b1;
                    consume  = fill_reg;
                    emit_res.kind = KIND_NO_START;
                    emit_res.dropped_count  = fill_reg;
                    emit_res.buffered_count = '0;
                    if (emit_fire)
                    begin
                        state_next = ST_TOP;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + COUNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_LEN_RD:
            begin
                state_next = ST_LEN_CHK;
            end
            ST_LEN_CHK:
            begin
                len_next = rd_data_reg;
                if (rd_data_reg > MAX_LEN)
                begin
                    emit_req = 1'b1;
                    consume  = COUNT_W'(1);
                    emit_res.kind = KIND_LEN_BAD;
                    emit_res.payload_length =
                        (rd_data_reg > 8'd63) ? 6'd63 : rd_data_reg[5:0];
                    emit_res.dropped_count  = COUNT_W'(1);
                    emit_res.buffered_count = fill_reg - COUNT_W'(1);
                    if (emit_fire)
                    begin
                        state_next = ST_TOP;
                    end
                end
                else if (fill_reg < (COUNT_W'(rd_data_reg[5:0]) + COUNT_W'(HEADER_BYTES + 1)))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_SUM_RD;
                end
            end
            ST_SUM_RD:
            begin
                state_next = ST_SUM_ADD;
            end
            ST_SUM_ADD:
            begin
                if (idx_reg == total - COUNT_W'(1))
                begin
                    if (rd_data_reg != sum_reg)
                    begin
                        emit_req = 1'b1;
                        consume  = COUNT_W'(1);
                        emit_res.kind = KIND_SUM_BAD;
                        emit_res.payload_length = len_reg[5:0];
                        emit_res.dropped_count  = COUNT_W'(1);
                        emit_res.received_sum   = rd_data_reg;
                        emit_res.expected_sum   = sum_reg;
                        emit_res.buffered_count = fill_reg - COUNT_W'(1);
                        if (emit_fire)
                        begin
                            state_next = ST_TOP;
                        end
                    end
                    else
                    begin
                        state_next = ST_HDR_EMIT;
                    end
                end
                else
                begin
                    sum_next = sum_reg + rd_data_reg;
                    case (idx_reg)
                        7'd1:    hdr_next[1] = rd_data_reg;
                        7'd2:    hdr_next[2] = rd_data_reg;
                        7'd3:    hdr_next[3] = rd_data_reg;
                        7'd4:    hdr_next[4] = rd_data_reg;
                        default: ;
                    endcase
                    idx_next   = idx_reg + COUNT_W'(1);
                    state_next = ST_SUM_RD;
                end
            end
            ST_HDR_EMIT:
            begin
                emit_req = 1'b1;
                emit_res.kind = KIND_HEADER;
                emit_res.device_id  = hdr_reg[1];
                emit_res.system_id  = hdr_reg[2];
                emit_res.message_id = hdr_reg[3];
                emit_res.seq_number = hdr_reg[4];
                emit_res.payload_length = len_reg[5:0];
                emit_res.buffered_count = fill_reg - total;
                if (emit_fire)
                begin
                    idx_next   = COUNT_W'(HEADER_BYTES);
                    state_next = ST_PAY_RD;
                end
            end
            ST_PAY_RD:
            begin
                if (idx_reg == total - COUNT_W'(1))
                begin
                    consume    = total;
                    state_next = ST_TOP;
                end
                else
                begin
                    state_next = ST_PAY_EMIT;
                end
            end
            ST_PAY_EMIT:
            begin
                emit_req = 1'b1;
                emit_res.kind = KIND_PAYLOAD;
                emit_res.device_id  = hdr_reg[1];
                emit_res.system_id  = hdr_reg[2];
                emit_res.message_id = hdr_reg[3];
                emit_res.seq_number = hdr_reg[4];
                emit_res.payload_length = len_reg[5:0];
                emit_res.payload_byte   = rd_data_reg;
                emit_res.buffered_count = fill_reg - total;
                if (emit_fire)
                begin
                    idx_next   = idx_reg + COUNT_W'(1);
                    state_next = ST_PAY_RD;
                end
            end
            ST_FINISH:
            begin
                // last staged result of this byte goes out with last set
                if (!held_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_fire = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (!emit_req || emit_fire)
        begin
            head_next = head_next + consume[ADDR_W-1:0];
            fill_next = fill_next - consume;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            fill_reg   <= '0;
            held_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            if (emit_fire)
            begin
                held_v_reg <= 1'b1;
            end
            else if (flush_fire)
            begin
                held_v_reg <= 1'b0;
            end
            if ((emit_fire && held_v_reg) || flush_fire)
            begin
                out_v_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        len_reg <= len_next;
        sum_reg <= sum_next;
        hdr_reg <= hdr_next;
        if (emit_fire)
        begin
            held_reg <= emit_res;
        end
        if ((emit_fire && held_v_reg) || flush_fire)
        begin
            out_reg <= out_next;
        end
    end

    // byte buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem[wr_addr] <= head.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign res.valid          = out_v_reg;
    assign res.kind           = out_reg.kind;
    assign res.device_id      = out_reg.device_id;
    assign res.system_id      = out_reg.system_id;
    assign res.message_id     = out_reg.message_id;
    assign res.seq_number     = out_reg.seq_number;
    assign res.payload_length = out_reg.payload_length;
    assign res.payload_byte   = out_reg.payload_byte;
    assign res.dropped_count  = out_reg.dropped_count;
    assign res.received_sum   = out_reg.received_sum;
    assign res.expected_sum   = out_reg.expected_sum;
    assign res.last           = out_reg.last;
    assign res.buffered_count = out_reg.buffered_count;

`include "resyncing_frame_deframer_assert.svh"

    `RFD_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= COUNT_W'(STORE_DEPTH))
    `RFD_ASSERT_NOW(a_idle_no_held, clk, rst_n, state_reg == ST_IDLE, !held_v_reg)
    `RFD_ASSERT_NOW(a_pay_in_frame, clk, rst_n,
        state_reg == ST_PAY_RD || state_reg == ST_PAY_EMIT,
        idx_reg < total && total <= fill_reg)
    `RFD_ASSERT_NEXT(a_flush_sets_last, clk, rst_n, flush_fire, out_v_reg && out_reg.last)

endmodule

`default_nettype wire
